FILE: rtl/chi_square_uniformity_test_macros.svh
// Assertion macros shared by the chi-square uniformity test RTL.
`ifndef CHI_SQUARE_UNIFORMITY_TEST_MACROS_SVH
`define CHI_SQUARE_UNIFORMITY_TEST_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define CSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("chi-square block check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define CSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("chi-square block check failed");

`endif

FILE: rtl/csu_pkg.sv
// Shared widths and constants of the chi-square uniformity test.
package csu_pkg;
    localparam int CSU_NUM_BINS = 100;
    localparam int CSU_SAMPLE_W = 24;
    localparam int CSU_CNT_W    = 20;
    localparam int CSU_OUT_W    = 36;
    localparam int CSU_FRAC_W   = 8;
    localparam logic [CSU_CNT_W-1:0] CSU_LEN_RESET = CSU_CNT_W'(10000);
endpackage

FILE: rtl/csu_sqacc.sv
// Pipelined scale, absolute difference, square and accumulate unit.
module csu_sqacc #(
    parameter int NUM_BINS = csu_pkg::CSU_NUM_BINS,
    parameter int SUM_W    = 45
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          in_valid,
    input  logic [csu_pkg::CSU_CNT_W-1:0] in_count,
    input  logic [csu_pkg::CSU_CNT_W-1:0] len,
    output logic                          busy,
    output logic [SUM_W-1:0]              sum
);
    import csu_pkg::*;

    localparam int NMUL_W   = $clog2(NUM_BINS + 1);
    localparam int SCALED_W = CSU_CNT_W + NMUL_W;
    localparam logic [NMUL_W-1:0] NUM_CONST = NMUL_W'(NUM_BINS);

    logic                    v1_reg, v2_reg, v3_reg;
    logic [SCALED_W-1:0]     scaled_reg;
    logic [SCALED_W-1:0]     diff_reg;
    logic [2*SCALED_W-1:0]   sq_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SCALED_W-1:0]     len_ext;
    logic [SCALED_W-1:0]     diff_next;

    always_comb begin
        len_ext   = SCALED_W'(len);
        diff_next = (scaled_reg >= len_ext) ? (scaled_reg - len_ext) : (len_ext - scaled_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        scaled_reg <= in_count * NUM_CONST;
        diff_reg   <= diff_next;
        sq_reg     <= diff_reg * diff_reg;
        if (clear) begin
            sum_reg <= '0;
        end else if (v3_reg) begin
            sum_reg <= sum_reg + SUM_W'(sq_reg);
        end
    end

    assign busy = v1_reg | v2_reg | v3_reg;
    assign sum  = sum_reg;
endmodule

FILE: rtl/csu_div.sv
// Restoring divider, one quotient bit per cycle.
module csu_div #(
    parameter int DIVIDEND_W = 53,
    parameter int DIVISOR_W  = 27
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  ge;

    always_comb begin
        rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
        ge        = rem_shift >= {1'b0, divisor_reg};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub : rem_shift;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: rtl/chi_square_uniformity_test.sv
// Pearson chi-square uniformity test over a stream of 24-bit samples.
//
// Input channel s_valid/s_ready/s_sample: one sample per item, a fraction of
// one. Each sample is counted in bin floor(sample * NUM_BINS / 2^24).
// Result channel m_valid/m_ready/m_chi_square_q8: one chi-square statistic,
// 8 fraction bits, saturated, after every samples_per_test samples.
// cfg_we/cfg_wdata write samples_per_test (zero acts as one).
//
// A sample passes three steps: accept, histogram read, histogram write; the
// read-modify-write of the bin memory means a new sample is accepted only
// after the last one is written. The item that ends a test also starts a walk
// over the bins, a square-accumulate drain, a restoring division of one bit
// per cycle over SUM_W+8 bits, then a load of the result register; s_ready
// is low throughout.
// After reset a clearing pass over the bins zeroes the bin memory while
// s_ready stays low. The result register holds while m_ready is low; sampling
// continues meanwhile, and a later test waits before its result is loaded.
module chi_square_uniformity_test #(
    parameter int NUM_BINS = csu_pkg::CSU_NUM_BINS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [csu_pkg::CSU_CNT_W-1:0]    cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [csu_pkg::CSU_SAMPLE_W-1:0] s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [csu_pkg::CSU_OUT_W-1:0]    m_chi_square_q8
);
    import csu_pkg::*;
    `include "chi_square_uniformity_test_macros.svh"

    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int NMUL_W   = $clog2(NUM_BINS + 1);
    localparam int SCALED_W = CSU_CNT_W + NMUL_W;
    localparam int SUM_W    = 2 * SCALED_W + BIN_W;
    localparam int DEN_W    = CSU_CNT_W + NMUL_W;
    localparam int DIV_W    = SUM_W + CSU_FRAC_W;
    localparam logic [NMUL_W-1:0] NUM_CONST = NMUL_W'(NUM_BINS);
    localparam logic [BIN_W-1:0]  LAST_BIN  = BIN_W'(NUM_BINS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_WR    = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_RES   = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [CSU_CNT_W-1:0]         len_reg;
    logic [CSU_CNT_W-1:0]         seen_reg, seen_next;
    logic [BIN_W-1:0]             bin_reg;
    logic [BIN_W-1:0]             idx_reg;
    logic                         walk_rv_reg;
    logic [CSU_CNT_W-1:0]         rd_data_reg;
    logic                         m_valid_reg;
    logic [CSU_OUT_W-1:0]         out_reg;
    logic [CSU_CNT_W-1:0]         hist_mem [NUM_BINS];

    logic [CSU_SAMPLE_W+NMUL_W-1:0] bin_prod;
    logic [CSU_CNT_W-1:0]         len_eff;
    logic [CSU_CNT_W-1:0]         seen_inc;
    logic                         test_end;
    logic                         mem_we;
    logic [BIN_W-1:0]             mem_waddr;
    logic [BIN_W-1:0]             mem_raddr;
    logic [CSU_CNT_W-1:0]         mem_wdata;
    logic                         acc_clear;
    logic                         acc_busy;
    logic [SUM_W-1:0]             acc_sum;
    logic                         div_start;
    logic                         div_busy;
    logic                         div_done;
    logic [DIV_W-1:0]             div_quo;
    logic [DEN_W-1:0]             denom;
    logic                         load_out;
    logic [CSU_OUT_W-1:0]         out_value;

    always_comb begin
        bin_prod   = s_sample * NUM_CONST;
        len_eff    = (len_reg == '0) ? CSU_CNT_W'(1) : len_reg;
        seen_inc   = seen_reg + 1'b1;
        test_end   = seen_inc >= len_eff;
        denom      = len_eff * NUM_CONST;
        out_value  = (|div_quo[DIV_W-1:CSU_OUT_W]) ? '1 : div_quo[CSU_OUT_W-1:0];
        s_ready    = (state_reg == ST_IDLE);
        state_next = state_reg;
        seen_next  = seen_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = '0;
        mem_raddr  = idx_reg;
        acc_clear  = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (idx_reg == LAST_BIN) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                mem_raddr  = bin_reg;
                state_next = ST_WR;
            end
            ST_WR: begin
                mem_we    = 1'b1;
                mem_waddr = bin_reg;
                mem_wdata = rd_data_reg + 1'b1;
                if (test_end) begin
                    seen_next  = '0;
                    acc_clear  = 1'b1;
                    state_next = ST_WALK;
                end else begin
                    seen_next  = seen_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                mem_we = 1'b1;
                if (idx_reg == LAST_BIN) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!walk_rv_reg && !acc_busy) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            len_reg     <= CSU_LEN_RESET;
            seen_reg    <= '0;
            idx_reg     <= '0;
            walk_rv_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seen_reg    <= seen_next;
            walk_rv_reg <= (state_reg == ST_WALK);
            if (cfg_we) begin
                len_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR || state_reg == ST_WALK) begin
                idx_reg <= (idx_reg == LAST_BIN) ? '0 : idx_reg + 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            bin_reg <= bin_prod[CSU_SAMPLE_W +: BIN_W];
        end
        if (load_out) begin
            out_reg <= out_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= hist_mem[mem_raddr];
    end

    csu_sqacc #(
        .NUM_BINS (NUM_BINS),
        .SUM_W    (SUM_W)
    ) u_sqacc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (acc_clear),
        .in_valid (walk_rv_reg),
        .in_count (rd_data_reg),
        .len      (len_eff),
        .busy     (acc_busy),
        .sum      (acc_sum)
    );

    csu_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({acc_sum, CSU_FRAC_W'(0)}),
        .divisor  (denom),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_valid         = m_valid_reg;
    assign m_chi_square_q8 = out_reg;

    `CSU_ASSERT_NOW(a_idle_quiet, state_reg == ST_IDLE, !acc_busy && !div_busy)
    `CSU_ASSERT_NEXT(a_accept_reads, s_valid && s_ready, state_reg == ST_RD)
    `CSU_ASSERT_NOW(a_walk_blocks, state_reg == ST_WALK || state_reg == ST_DIV, !s_ready)
    `CSU_ASSERT_NOW(a_idx_range, state_reg == ST_WALK || state_reg == ST_CLEAR,
                    idx_reg <= LAST_BIN)
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the chi-square uniformity test block.
`timescale 1ns / 100ps

module tb;
    import csu_pkg::*;

    localparam int ITEMS_TOTAL = 1350;
    localparam int IDLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int BIN_IDX_W = $clog2(CSU_NUM_BINS);
    localparam logic [CSU_CNT_W-1:0] LEN_MAX = '1;
    localparam logic [CSU_SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [CSU_OUT_W-1:0] CHI_MAX = '1;

    typedef enum int {PAT_UNIFORM, PAT_CLUSTER, PAT_EDGE} sample_pattern_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CSU_CNT_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CSU_SAMPLE_W-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CSU_OUT_W-1:0] m_chi_square_q8;

    logic [CSU_CNT_W-1:0] hist_count [CSU_NUM_BINS];
    logic [CSU_CNT_W-1:0] samples_in_test;
    logic [CSU_CNT_W-1:0] test_length;
    logic [CSU_OUT_W-1:0] expected_chi [$];
    int items_sent = 0;
    int mismatch_count = 0;
    int sink_hold = 0;
    int stall_cycles = 0;
    bit no_idle = 1'b0;

    chi_square_uniformity_test #(
        .NUM_BINS(CSU_NUM_BINS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample(s_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_chi_square_q8(m_chi_square_q8)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [CSU_SAMPLE_W-1:0] bin_edge(input int b);
        return CSU_SAMPLE_W'(((longint'(b) << CSU_SAMPLE_W) + CSU_NUM_BINS - 1) / CSU_NUM_BINS);
    endfunction

    function automatic void clear_histogram();
        foreach (hist_count[b]) hist_count[b] = '0;
        samples_in_test = '0;
    endfunction

    function automatic logic [CSU_OUT_W-1:0] chi_square_of(input logic [CSU_CNT_W-1:0] len);
        logic [63:0] acc, denom, quot, rem, scaled, diff;
        acc = '0;
        denom = 64'(CSU_NUM_BINS) * 64'(len);
        for (int b = 0; b < CSU_NUM_BINS; b++) begin
            scaled = 64'(CSU_NUM_BINS) * 64'(hist_count[b]);
            diff = (scaled >= 64'(len)) ? scaled - 64'(len) : 64'(len) - scaled;
            acc += diff * diff;
        end
        quot = acc / denom;
        rem = acc % denom;
        if (quot > 64'(CHI_MAX >> CSU_FRAC_W)) return CHI_MAX;
        return CSU_OUT_W'((quot << CSU_FRAC_W) + ((rem << CSU_FRAC_W) / denom));
    endfunction

    function automatic void predict_sample(input logic [CSU_SAMPLE_W-1:0] s);
        logic [31:0] scaled;
        logic [BIN_IDX_W-1:0] bin_idx;
        logic [CSU_CNT_W-1:0] len;
        scaled = 32'(s) * 32'(CSU_NUM_BINS);
        bin_idx = scaled[CSU_SAMPLE_W +: BIN_IDX_W];
        len = (test_length == '0) ? CSU_CNT_W'(1) : test_length;
        if (scaled[31:CSU_SAMPLE_W] < CSU_NUM_BINS)
            hist_count[bin_idx] += 1'b1;
        samples_in_test += 1'b1;
        if (samples_in_test >= len) begin
            expected_chi.push_back(chi_square_of(len));
            clear_histogram();
        end
    endfunction

    task automatic send_sample(input logic [CSU_SAMPLE_W-1:0] s);
        int g;
        g = idle_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= s;
        do @(posedge aclk); while (!s_ready);
        predict_sample(s);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_chi.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_test_length(input logic [CSU_CNT_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        test_length = v;
    endtask

    task automatic report_mismatch(input logic [CSU_OUT_W-1:0] want, got, input bit orphan);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (orphan)
                $display("unexpected chi_square_q8 result %0d", got);
            else
                $display("chi_square_q8 mismatch: expected %0d got %0d", want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        logic [CSU_OUT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chi.size() == 0) begin
                report_mismatch('0, m_chi_square_q8, 1'b1);
            end else begin
                want = expected_chi.pop_front();
                if (m_chi_square_q8 !== want) report_mismatch(want, m_chi_square_q8, 1'b0);
            end
        end
    end

    always @(posedge aclk) begin : result_sink
        int g;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 1) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_hold == 1) begin
            sink_hold <= 0;
            m_ready <= 1'b1;
        end else begin
            g = ((m_valid && m_ready) || $urandom_range(0, 15) == 0) ? idle_len() : 0;
            m_ready <= (g == 0);
            sink_hold <= g;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("chi_square_uniformity_test regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic test_bin_edges();
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(bin_edge(1) - 1'b1);
        send_sample(bin_edge(1));
        send_sample(bin_edge(CSU_NUM_BINS - 1) - 1'b1);
        send_sample(bin_edge(CSU_NUM_BINS - 1));
    endtask

    task automatic test_max_length();
        wait_idle();
        write_test_length(LEN_MAX);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        send_sample(24'h800000);
    endtask

    task automatic test_length_lowered();
        wait_idle();
        write_test_length(CSU_CNT_W'(5));
        for (int i = 0; i < 6; i++) send_sample(bin_edge(i * 17));
    endtask

    task automatic test_zero_length();
        wait_idle();
        write_test_length('0);
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(24'h7FFFFF);
        send_sample(bin_edge(1));
    endtask

    task automatic test_single_bin();
        wait_idle();
        write_test_length(CSU_CNT_W'(8));
        repeat (8) send_sample(SAMPLE_MAX);
    endtask

    task automatic test_random_phases();
        int r, k, nctr;
        logic [CSU_CNT_W-1:0] len;
        logic [CSU_SAMPLE_W-1:0] ctr [3];
        logic [CSU_SAMPLE_W-1:0] s;
        sample_pattern_t pat;
        while (items_sent < ITEMS_TOTAL) begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 8) len = '0;
            else if (r < 16) len = CSU_CNT_W'(1);
            else if (r < 76) len = CSU_CNT_W'($urandom_range(2, 32));
            else if (r < 94) len = CSU_CNT_W'($urandom_range(33, 150));
            else len = LEN_MAX;
            write_test_length(len);
            no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            pat = (r < 55) ? PAT_UNIFORM : (r < 85) ? PAT_CLUSTER : PAT_EDGE;
            nctr = $urandom_range(1, 3);
            foreach (ctr[i]) ctr[i] = CSU_SAMPLE_W'($urandom);
            k = $urandom_range(1, 60);
            repeat (k) begin
                case (pat)
                    PAT_UNIFORM: begin
                        s = CSU_SAMPLE_W'($urandom);
                    end
                    PAT_CLUSTER: begin
                        s = ctr[$urandom_range(0, nctr - 1)] ^ CSU_SAMPLE_W'($urandom_range(0, 4095));
                    end
                    default: begin
                        s = bin_edge($urandom_range(1, CSU_NUM_BINS - 1));
                        if ($urandom_range(0, 1) == 0) s = s - 1'b1;
                    end
                endcase
                send_sample(s);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        test_length = CSU_LEN_RESET;
        clear_histogram();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_bin_edges();
        test_max_length();
        test_length_lowered();
        test_zero_length();
        test_single_bin();
        test_random_phases();
        s_valid <= 1'b0;
        while (expected_chi.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("chi_square_uniformity_test regression: pass");
        else
            $display("chi_square_uniformity_test regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/csu_pkg.sv
rtl/csu_sqacc.sv
rtl/csu_div.sv
rtl/chi_square_uniformity_test.sv
tb/tb.sv
